FILE: design/sse_pkg.sv
// package for the server-sent-events stream parser
// holds line-mode and result-kind codes, character constants and prefix tables
// no dependencies
`default_nettype none

package sse_pkg;

    // line parse modes
    typedef enum logic [2:0] {
        MODE_START      = 3'd0,
        MODE_MATCH_DATA = 3'd1,
        MODE_MATCH_NAME = 3'd2,
        MODE_IN_DATA    = 3'd3,
        MODE_IN_NAME    = 3'd4,
        MODE_SKIP       = 3'd5
    } t_line_mode;

    // result kinds
    typedef enum logic [2:0] {
        KIND_NONE         = 3'd0,
        KIND_DATA_CLEARED = 3'd1,
        KIND_DATA_BYTE    = 3'd2,
        KIND_NAME_CLEARED = 3'd3,
        KIND_NAME_BYTE    = 3'd4,
        KIND_DELIVER      = 3'd5,
        KIND_DISCARD      = 3'd6
    } t_kind;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [2:0] DATA_PREFIX_LEN = 3'd6;
    localparam logic [2:0] NAME_PREFIX_LEN = 3'd7;

    // "data: " one character per position
    function automatic logic [7:0] data_prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h64;  // d
            3'd1:    c = 8'h61;  // a
            3'd2:    c = 8'h74;  // t
            3'd3:    c = 8'h61;  // a
            3'd4:    c = 8'h3a;  // :
            3'd5:    c = 8'h20;  // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "event: " one character per position
    function automatic logic [7:0] name_prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h65;  // e
            3'd1:    c = 8'h76;  // v
            3'd2:    c = 8'h65;  // e
            3'd3:    c = 8'h6e;  // n
            3'd4:    c = 8'h74;  // t
            3'd5:    c = 8'h3a;  // :
            3'd6:    c = 8'h20;  // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/sse_event_stream_parser_top.sv
// server-sent-events stream parser, top level
// framing state machine between an input register and a result register
// depends on sse_pkg
//
// Usage:
//   Input channel (i_valid / o_ready / i_byte_in) carries one raw stream byte
//   per transfer. Output channel (o_valid / i_ready / o_kind / o_byte_out)
//   carries exactly one result per input byte, in input order: a kind code
//   (none, data/name cleared, data/name byte, event deliver/discard) and the
//   payload byte for data and name bytes, zero otherwise.
//   Throughput: one byte per cycle sustained while i_ready is high; the
//   framing state updates as a byte moves from the input register to the
//   result register, so only a receiver stall holds the rate below one
//   transfer per clock.
//   Path: a transferred byte is held in the input register, then in the
//   result register, whose content drives the output.
//   Reset: synchronous active-low i_rst_n empties both registers and puts the
//   framer at line start with no pending line end, no CR seen and no data.
//   Receiver stall: the result register holds its value and the input
//   register keeps the byte behind it; once both hold a byte o_ready drops
//   in the same cycle (it follows i_ready) until the result is taken.
//   No byte is dropped or repeated.
`default_nettype none

module sse_event_stream_parser_top
    import sse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte_in,
    // result output
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_byte_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_byte;

    // framing state
    t_line_mode r_line_mode,   n_line_mode;
    logic [2:0] r_prefix_pos,  n_prefix_pos;
    logic       r_ends_in_row, n_ends_in_row;
    logic       r_last_was_cr, n_last_was_cr;
    logic       r_data_nonempty, n_data_nonempty;

    // combinational result
    t_kind      w_kind;
    logic [7:0] w_byte;

    // shared decode of the byte in the input register
    logic w_take;
    logic w_absorb;
    logic w_line_end;
    logic w_data_ok;
    logic w_name_ok;
    logic w_data_done;
    logic w_name_done;

    // a byte moves forward when the result register is free or being drained
    assign w_take  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_take;

    assign w_absorb   = r_last_was_cr && (r_in_byte == CH_LF);
    assign w_line_end = (r_in_byte == CH_CR) || (r_in_byte == CH_LF);
    assign w_data_ok  = (r_prefix_pos < DATA_PREFIX_LEN)
                        && (data_prefix_char(r_prefix_pos) == r_in_byte);
    assign w_name_ok  = (r_prefix_pos < NAME_PREFIX_LEN)
                        && (name_prefix_char(r_prefix_pos) == r_in_byte);
    assign w_data_done = w_data_ok && (r_prefix_pos + 3'd1 == DATA_PREFIX_LEN);
    assign w_name_done = w_name_ok && (r_prefix_pos + 3'd1 == NAME_PREFIX_LEN);

    // next framing state
    always_comb begin
        n_line_mode     = r_line_mode;
        n_prefix_pos    = r_prefix_pos;
        n_ends_in_row   = r_ends_in_row;
        n_last_was_cr   = r_last_was_cr;
        n_data_nonempty = r_data_nonempty;
        if (w_absorb) begin
            n_last_was_cr = 1'b0;
        end else if (w_line_end) begin
            n_last_was_cr = (r_in_byte == CH_CR);
            n_line_mode   = MODE_START;
            n_prefix_pos  = 3'd0;
            if (r_ends_in_row) begin
                n_ends_in_row   = 1'b0;
                n_data_nonempty = 1'b0;
            end else begin
                n_ends_in_row = 1'b1;
            end
        end else begin
            n_ends_in_row = 1'b0;
            n_last_was_cr = 1'b0;
            case (r_line_mode)
                MODE_START: begin
                    if (r_in_byte == data_prefix_char(3'd0)) begin
                        n_line_mode  = MODE_MATCH_DATA;
                        n_prefix_pos = 3'd1;
                    end else if (r_in_byte == name_prefix_char(3'd0)) begin
                        n_line_mode  = MODE_MATCH_NAME;
                        n_prefix_pos = 3'd1;
                    end else begin
                        n_line_mode  = MODE_SKIP;
                        n_prefix_pos = 3'd0;
                    end
                end
                MODE_MATCH_DATA: begin
                    if (!w_data_ok) begin
                        n_line_mode  = MODE_SKIP;
                        n_prefix_pos = 3'd0;
                    end else if (w_data_done) begin
                        n_line_mode     = MODE_IN_DATA;
                        n_prefix_pos    = 3'd0;
                        n_data_nonempty = 1'b0;
                    end else begin
                        n_prefix_pos = r_prefix_pos + 3'd1;
                    end
                end
                MODE_MATCH_NAME: begin
                    if (!w_name_ok) begin
                        n_line_mode  = MODE_SKIP;
                        n_prefix_pos = 3'd0;
                    end else if (w_name_done) begin
                        n_line_mode  = MODE_IN_NAME;
                        n_prefix_pos = 3'd0;
                    end else begin
                        n_prefix_pos = r_prefix_pos + 3'd1;
                    end
                end
                MODE_IN_DATA: begin
                    n_data_nonempty = 1'b1;
                end
                MODE_IN_NAME: begin
                end
                default: begin
                    n_line_mode  = MODE_SKIP;
                    n_prefix_pos = 3'd0;
                end
            endcase
        end
    end

    // result for the byte in the input register
    always_comb begin
        w_kind = KIND_NONE;
        w_byte = 8'd0;
        if (w_absorb) begin
            w_kind = KIND_NONE;
        end else if (w_line_end) begin
            if (r_ends_in_row) begin
                w_kind = r_data_nonempty ? KIND_DELIVER : KIND_DISCARD;
            end
        end else begin
            case (r_line_mode)
                MODE_MATCH_DATA: begin
                    if (w_data_done) begin
                        w_kind = KIND_DATA_CLEARED;
                    end
                end
                MODE_MATCH_NAME: begin
                    if (w_name_done) begin
                        w_kind = KIND_NAME_CLEARED;
                    end
                end
                MODE_IN_DATA: begin
                    w_kind = KIND_DATA_BYTE;
                    w_byte = r_in_byte;
                end
                MODE_IN_NAME: begin
                    w_kind = KIND_NAME_BYTE;
                    w_byte = r_in_byte;
                end
                default: begin
                    w_kind = KIND_NONE;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte_in;
        end
    end

    // framing state advances once per byte moved forward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode     <= MODE_START;
            r_prefix_pos    <= 3'd0;
            r_ends_in_row   <= 1'b0;
            r_last_was_cr   <= 1'b0;
            r_data_nonempty <= 1'b0;
        end else if (w_take) begin
            r_line_mode     <= n_line_mode;
            r_prefix_pos    <= n_prefix_pos;
            r_ends_in_row   <= n_ends_in_row;
            r_last_was_cr   <= n_last_was_cr;
            r_data_nonempty <= n_data_nonempty;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_byte_out = r_out_byte;

    // payload byte is zero unless the result tags a data or name byte
    a_byte_only_tagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_DATA_BYTE && o_kind != KIND_NAME_BYTE)
            |-> (o_byte_out == 8'd0))
        else $error("payload byte set on an untagged result");

    // a pending CR always leaves the framer at line start
    a_cr_at_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_was_cr |-> (r_line_mode == MODE_START))
        else $error("CR pending outside line start");

    // inside a field the prefix counter is idle
    a_field_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_mode == MODE_IN_DATA || r_line_mode == MODE_IN_NAME)
            |-> (r_prefix_pos == 3'd0))
        else $error("prefix counter not cleared inside a field");

    // a partial data-prefix match has matched between one and five characters
    a_data_match_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_mode == MODE_MATCH_DATA)
            |-> (r_prefix_pos != 3'd0 && r_prefix_pos < DATA_PREFIX_LEN))
        else $error("data prefix position out of range");

endmodule

`default_nettype wire
